/* rtl/sata_cdb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the SATA command descriptor builder.
// Depends on nothing; imported by the top level.
package sata_cdb_pkg;

    // Field widths of one request.
    localparam int CMD_W  = 8;
    localparam int SIZE_W = 28;
    localparam int LBA_W  = 48;
    localparam int BUF_W  = 64;
    localparam int BUSY_W = 32;

    // Field widths of one result.
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 5;
    localparam int DCNT_W  = 6;
    localparam int COUNT_W = 16;
    localparam int DEV_W   = 8;
    localparam int ELEN_W  = 22;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 184;

    localparam int MAX_ENTRIES = 63;
    localparam int SLOT_COUNT  = 32;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NO_SLOT = 2'd2;

    // Register index, taken from paddr[2].
    localparam logic REG_LONG_MODE = 1'b0;

    localparam logic [DEV_W-1:0] DEV_LBA_MODE = 8'h40;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic               last;
        logic [DCNT_W-1:0]  dcount;
        logic               write_flag;
        logic [CMD_W-1:0]   fis_command;
        logic [COUNT_W-1:0] fis_count;
        logic [LBA_W-1:0]   fis_address;
        logic [DEV_W-1:0]   fis_device;
        logic [BUF_W-1:0]   entry_address;
        logic [ELEN_W-1:0]  entry_len_m1;
    } result_t;

endpackage

/* rtl/sata_command_descriptor_builder_top.sv */
`timescale 1ns / 1ps
// Top level of the SATA command descriptor builder: slot pick, block and
// chunk count division, header and scatter entry generation. Uses sata_cdb_pkg.
//
// Usage: a request enters on the s_ stream (command, direction, byte size,
// start LBA, buffer base, busy slot mask). The block picks the lowest free
// slot below SLOT_COUNT. With no free slot it returns one result of kind
// "no slot" with tlast set. Otherwise it returns a header result and then one
// scatter entry per chunk of at most CHUNK_BYTES bytes, at most 63 entries,
// tlast on the final one. tuser carries the result kind.
// Sequence: after acceptance one shared multiplier divides by the block size and
// then by the chunk size through reciprocal constants, in states ST_DIV_BLK and
// ST_DIV_CHK, before the header enters the output register; entries then follow
// one per cycle while m_tready does not stall the output.
// s_tready is high only while no request is in work; the next request can be
// accepted while the final result still sits in the output register.
// A stall on m_tready holds the result in the output register and pauses
// the sequencer. Reset empties the output register, returns the sequencer to
// idle and sets long_address_mode to 1. The mode register is written over the
// APB port at address 0 and must only change while the block is idle.
module sata_command_descriptor_builder_top
    import sata_cdb_pkg::*;
#(
    parameter int CHUNK_BYTES = 4194304,
    parameter int BLOCK_BYTES = 512
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ata_command[7:0], is_write[8], byte_size[36:9], block_address[84:37],
    // buffer_address[148:85], busy_slots[180:149], zero[183:181]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot[4:0], descriptor_count[10:5], write_flag[11], fis_command[19:12],
    // fis_count[35:20], fis_address[83:36], fis_device[91:84],
    // entry_address[155:92], entry_length_minus_one[177:156], zero[183:178]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // kind[1:0]
    output logic [KIND_W-1:0]     m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int DIVD_W = SIZE_W + 1;
    localparam int RCP_W  = DIVD_W + 1;
    localparam int PROD_W = DIVD_W + RCP_W;
    localparam int BLK_SH = DIVD_W + $clog2(BLOCK_BYTES);
    localparam int CHK_SH = DIVD_W + $clog2(CHUNK_BYTES);
    // Rounded-up reciprocals; exact for every dividend below 2^DIVD_W.
    localparam longint unsigned BLK_RCP =
        ((64'd1 << BLK_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam longint unsigned CHK_RCP =
        ((64'd1 << CHK_SH) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_BLK,
        ST_DIV_CHK,
        ST_HDR,
        ST_ENT,
        ST_NO_SLOT
    } state_t;

    state_t              state_reg;
    logic                mode_reg;
    logic                m_valid_reg;
    result_t             out_reg;

    logic [CMD_W-1:0]    cmd_reg;
    logic                wr_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [LBA_W-1:0]    lba_reg;
    logic [BUF_W-1:0]    buf_reg;
    logic [SLOT_W-1:0]   slot_reg;

    logic [DIVD_W-1:0]   q_reg;
    logic [COUNT_W-1:0]  blocks_reg;
    logic [DCNT_W-1:0]   chunks_reg;

    logic [SIZE_W-1:0]   bytes_rem_reg;
    logic [BUF_W-1:0]    addr_reg;
    logic [DCNT_W-1:0]   ent_cnt_reg;

    // Request unpacking.
    logic [CMD_W-1:0]    in_cmd;
    logic                in_wr;
    logic [SIZE_W-1:0]   in_size;
    logic [LBA_W-1:0]    in_lba;
    logic [BUF_W-1:0]    in_buf;
    logic [BUSY_W-1:0]   in_busy;

    assign in_cmd  = s_tdata[7:0];
    assign in_wr   = s_tdata[8];
    assign in_size = s_tdata[36:9];
    assign in_lba  = s_tdata[84:37];
    assign in_buf  = s_tdata[148:85];
    assign in_busy = s_tdata[180:149];

    // Lowest free slot below SLOT_COUNT.
    logic                slot_found;
    logic [SLOT_W-1:0]   slot_pick;

    always_comb
    begin
        slot_found = 1'b0;
        slot_pick  = '0;
        for (int i = BUSY_W - 1; i >= 0; i--)
        begin
            if (!in_busy[i] && (i < SLOT_COUNT))
            begin
                slot_found = 1'b1;
                slot_pick  = SLOT_W'(i);
            end
        end
    end

    // Shared multiplier: block count first, then chunk count.
    logic [RCP_W-1:0]    mul_b;
    logic [PROD_W-1:0]   product;
    logic [DIVD_W-1:0]   quotient;
    logic [DIVD_W-1:0]   blk_dividend;
    logic [DIVD_W-1:0]   chk_dividend;
    logic [DCNT_W-1:0]   chunks_next;

    assign mul_b        = (state_reg == ST_DIV_CHK) ? RCP_W'(CHK_RCP) : RCP_W'(BLK_RCP);
    assign product      = PROD_W'(q_reg) * PROD_W'(mul_b);
    assign quotient     = (state_reg == ST_DIV_CHK) ? DIVD_W'(product >> CHK_SH)
                                                    : DIVD_W'(product >> BLK_SH);
    assign blk_dividend = {1'b0, in_size} + DIVD_W'(BLOCK_BYTES - 1);
    assign chk_dividend = {1'b0, size_reg} + DIVD_W'(CHUNK_BYTES - 1);
    assign chunks_next  = (quotient > DIVD_W'(MAX_ENTRIES)) ? DCNT_W'(MAX_ENTRIES)
                                                             : quotient[DCNT_W-1:0];

    // Chunk length compare for the scatter walk.
    logic [SIZE_W:0]     sub_full;
    logic                borrow;

    assign sub_full = {1'b0, bytes_rem_reg} - {1'b0, SIZE_W'(CHUNK_BYTES)};
    assign borrow   = sub_full[SIZE_W];

    // Scatter entry arithmetic.
    logic                ent_fits;
    logic [SIZE_W-1:0]   ent_len;
    logic [SIZE_W-1:0]   ent_len_m1;
    logic [SIZE_W-1:0]   bytes_rem_next;
    logic [BUF_W-1:0]    addr_next;
    logic                ent_last;

    assign ent_fits       = borrow || (sub_full[SIZE_W-1:0] == '0);
    assign ent_len        = ent_fits ? bytes_rem_reg : SIZE_W'(CHUNK_BYTES);
    assign ent_len_m1     = ent_len - SIZE_W'(1);
    assign bytes_rem_next = ent_fits ? '0 : sub_full[SIZE_W-1:0];
    assign addr_next      = addr_reg + BUF_W'(ent_len);
    assign ent_last       = ((ent_cnt_reg + DCNT_W'(1)) == chunks_reg);

    // Header fields in the selected address layout, plus the entry and no-slot results.
    result_t             hdr;
    result_t             ent;
    result_t             err;

    always_comb
    begin
        hdr             = '0;
        hdr.kind        = KIND_HEADER;
        hdr.slot        = slot_reg;
        hdr.last        = (chunks_reg == '0);
        hdr.dcount      = chunks_reg;
        hdr.write_flag  = wr_reg;
        hdr.fis_command = cmd_reg;
        if (mode_reg)
        begin
            hdr.fis_count   = blocks_reg;
            hdr.fis_address = lba_reg;
            hdr.fis_device  = DEV_LBA_MODE;
        end
        else
        begin
            hdr.fis_count   = {8'd0, blocks_reg[7:0]};
            hdr.fis_address = {24'd0, lba_reg[23:0]};
            hdr.fis_device  = DEV_LBA_MODE | {4'd0, lba_reg[27:24]};
        end

        ent               = '0;
        ent.kind          = KIND_ENTRY;
        ent.slot          = slot_reg;
        ent.last          = ent_last;
        ent.entry_address = addr_reg;
        ent.entry_len_m1  = ent_len_m1[ELEN_W-1:0];

        err      = '0;
        err.kind = KIND_NO_SLOT;
        err.last = 1'b1;
    end

    logic out_free;
    logic emit;
    logic cfg_write;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = out_free && ((state_reg == ST_HDR) || (state_reg == ST_ENT) ||
                                    (state_reg == ST_NO_SLOT));
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b1;
            m_valid_reg   <= 1'b0;
            bytes_rem_reg <= '0;
            addr_reg      <= '0;
            ent_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_LONG_MODE))
            begin
                mode_reg <= pwdata[0];
            end

            // The output register refills in the cycle it drains when a result is ready.
            m_valid_reg <= emit || (m_valid_reg && !m_tready);

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg  <= in_cmd;
                        wr_reg   <= in_wr;
                        size_reg <= in_size;
                        lba_reg  <= in_lba;
                        buf_reg  <= in_buf;
                        slot_reg <= slot_pick;
                        q_reg    <= blk_dividend;
                        state_reg <= slot_found ? ST_DIV_BLK : ST_NO_SLOT;
                    end
                end
                ST_DIV_BLK:
                begin
                    blocks_reg <= quotient[COUNT_W-1:0];
                    q_reg      <= chk_dividend;
                    state_reg  <= ST_DIV_CHK;
                end
                ST_DIV_CHK:
                begin
                    chunks_reg    <= chunks_next;
                    bytes_rem_reg <= size_reg;
                    addr_reg      <= buf_reg;
                    ent_cnt_reg   <= '0;
                    state_reg     <= ST_HDR;
                end
                ST_HDR:
                begin
                    if (out_free)
                    begin
                        out_reg   <= hdr;
                        state_reg <= (chunks_reg == '0) ? ST_IDLE : ST_ENT;
                    end
                end
                ST_ENT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= ent;
                        bytes_rem_reg <= bytes_rem_next;
                        addr_reg      <= addr_next;
                        ent_cnt_reg   <= ent_cnt_reg + DCNT_W'(1);
                        if (ent_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_NO_SLOT:
                begin
                    if (out_free)
                    begin
                        out_reg   <= err;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0,
                       out_reg.entry_len_m1,
                       out_reg.entry_address,
                       out_reg.fis_device,
                       out_reg.fis_address,
                       out_reg.fis_count,
                       out_reg.fis_command,
                       out_reg.write_flag,
                       out_reg.dcount,
                       out_reg.slot};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LONG_MODE) ? {31'd0, mode_reg} : 32'd0;

    // The entry count never passes the bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        ent_cnt_reg <= DCNT_W'(MAX_ENTRIES))
        else $error("entry counter beyond bound");

    // Every entry still in work describes at least one byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENT) |-> (bytes_rem_reg != '0))
        else $error("scatter walk ran out of bytes");

    // A no-slot answer is always the final result of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_reg.kind == KIND_NO_SLOT)) |-> out_reg.last)
        else $error("no-slot result without last");

    // A header closes the request exactly when it announces no entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_reg.kind == KIND_HEADER)) |->
            (out_reg.last == (out_reg.dcount == '0)))
        else $error("header last flag disagrees with entry count");

    // No entry is longer than one chunk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_reg.kind == KIND_ENTRY)) |->
            (out_reg.entry_len_m1 <= ELEN_W'(CHUNK_BYTES - 1)))
        else $error("entry longer than a chunk");

endmodule
